[rtl/vmt_pkg.sv]
// Shared widths, types and helpers for the von Mises maximum tracker.
package vmt_pkg;

  localparam int STRESS_W = 24;
  localparam int VM_W     = 25;
  localparam int NUM_W    = 21;
  localparam int N_COMP   = 6;
  localparam int N_DIFF   = 3;

  // A difference of two stresses needs one extra bit; its square fits twice that.
  localparam int DIFF_W = STRESS_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  // The accumulator holds the normal sum plus six times the shear sum.
  localparam int ACC_W  = PROD_W + 1;
  localparam int RAD_W  = ACC_W - 1;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W);

  localparam logic [NUM_W-1:0] MAX_ELEMENTS = NUM_W'(1048576);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Multiply sequencer phases: products at phases below PH_MUL_END, shear
  // products from PH_SHEAR on, root launched at PH_ROOT_GO.
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_SHEAR   = PHASE_W'(N_DIFF);
  localparam logic [PHASE_W-1:0] PH_MUL_END = PHASE_W'(N_COMP);
  localparam logic [PHASE_W-1:0] PH_ROOT_GO = PHASE_W'(N_COMP + 1);

  typedef logic [STRESS_W-1:0] stress_t;
  typedef logic [DIFF_W-1:0]   diff_t;

  typedef struct packed {
    logic [N_DIFF-1:0][DIFF_W-1:0]   diff;
    logic [N_COMP-1:0][STRESS_W-1:0] comp;
    logic                            start;
  } item_t;

  typedef struct packed {
    logic [VM_W-1:0]                 vm_stress;
    logic [NUM_W-1:0]                element_number;
    logic                            new_max;
    logic [VM_W-1:0]                 max_von_mises;
    logic [NUM_W-1:0]                max_element;
    logic [N_COMP-1:0][STRESS_W-1:0] max_comp;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  function automatic diff_t sext(input stress_t v);
    return {v[STRESS_W-1], v};
  endfunction

endpackage

[rtl/vmt_front.sv]
// Input stage: forms the normal stress differences and queues the words.
module vmt_front (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [vmt_pkg::N_COMP-1:0][vmt_pkg::STRESS_W-1:0] in_comp,
  input  logic                                          in_start,
  output logic                                          q_valid,
  input  logic                                          q_ready,
  output vmt_pkg::item_t                                q_item
);

  vmt_pkg::item_t                    q_mem_r [vmt_pkg::QUEUE_DEPTH];
  logic [vmt_pkg::QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [vmt_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  vmt_pkg::item_t                    item;
  logic                              push, pop;

  always_comb begin
    item.diff[0] = vmt_pkg::sext(in_comp[0]) - vmt_pkg::sext(in_comp[1]);
    item.diff[1] = vmt_pkg::sext(in_comp[1]) - vmt_pkg::sext(in_comp[2]);
    item.diff[2] = vmt_pkg::sext(in_comp[2]) - vmt_pkg::sext(in_comp[0]);
    item.comp    = in_comp;
    item.start   = in_start;
  end

  assign in_ready = (cnt_r != vmt_pkg::QCNT_W'(vmt_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

[rtl/vmt_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module vmt_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vmt_pkg::RAD_W-1:0]   rad,
  output logic                        done,
  output logic [vmt_pkg::ROOT_W-1:0]  root
);

  logic [vmt_pkg::RAD_W-1:0]   rad_r;
  logic [vmt_pkg::REM_W-1:0]   rem_r, rem_sh, trial, rem_nxt;
  logic [vmt_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [vmt_pkg::STEP_W-1:0]  step_r;
  logic                        busy_r, done_r, ge;

  always_comb begin
    rem_sh   = {rem_r[vmt_pkg::REM_W-3:0], rad_r[vmt_pkg::RAD_W-1 -: 2]};
    trial    = vmt_pkg::REM_W'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[vmt_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == vmt_pkg::STEP_W'(vmt_pkg::ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[vmt_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/vmt_back.sv]
// Back end: square-accumulate sequencer, root launch and maximum tracking.
module vmt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  vmt_pkg::item_t             q_item,
  output logic                       root_start,
  output logic [vmt_pkg::RAD_W-1:0]  root_rad,
  input  logic                       root_done,
  input  logic [vmt_pkg::VM_W-1:0]   root_val,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vmt_pkg::result_t           out_res
);

  vmt_pkg::back_state_t               state_r, state_nxt;
  logic [vmt_pkg::PHASE_W-1:0]        phase_r;
  vmt_pkg::item_t                     ops_r;
  vmt_pkg::diff_t                     op, mag;
  logic [vmt_pkg::PROD_W-1:0]         sq, prod_r;
  logic                               prod_shear_r, prod_vld_r;
  logic [vmt_pkg::ACC_W-1:0]          acc_r, prod_x, weighted;
  logic                               pop, load, out_valid_r;

  logic [vmt_pkg::NUM_W-1:0]          cnt_r, cnt_base, cnt_new;
  logic [vmt_pkg::VM_W-1:0]           best_r, best_base;
  logic [vmt_pkg::NUM_W-1:0]          best_elem_r, elem_base;
  logic [vmt_pkg::N_COMP-1:0][vmt_pkg::STRESS_W-1:0] best_comp_r, comp_base;
  logic                               is_new;
  vmt_pkg::result_t                   res_nxt, res_r;

  assign q_ready = (state_r == vmt_pkg::ST_IDLE);
  assign pop     = q_valid && q_ready;
  assign load    = (state_r == vmt_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Operand select: three differences, then the three shears.
  always_comb begin
    unique case (phase_r)
      3'd0:    op = ops_r.diff[0];
      3'd1:    op = ops_r.diff[1];
      3'd2:    op = ops_r.diff[2];
      3'd3:    op = vmt_pkg::sext(ops_r.comp[3]);
      3'd4:    op = vmt_pkg::sext(ops_r.comp[4]);
      3'd5:    op = vmt_pkg::sext(ops_r.comp[5]);
      default: op = '0;
    endcase
    mag      = op[vmt_pkg::DIFF_W-1] ? (~op + 1'b1) : op;
    sq       = mag * mag;
    prod_x   = vmt_pkg::ACC_W'(prod_r);
    weighted = prod_shear_r ? ((prod_x << 2) + (prod_x << 1)) : prod_x;
  end

  assign root_start = (state_r == vmt_pkg::ST_MUL) && (phase_r == vmt_pkg::PH_ROOT_GO);
  assign root_rad   = acc_r[vmt_pkg::ACC_W-1:1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vmt_pkg::ST_IDLE: if (pop) state_nxt = vmt_pkg::ST_MUL;
      vmt_pkg::ST_MUL:  if (root_start) state_nxt = vmt_pkg::ST_ROOT;
      vmt_pkg::ST_ROOT: if (root_done) state_nxt = vmt_pkg::ST_DONE;
      vmt_pkg::ST_DONE: if (load) state_nxt = vmt_pkg::ST_IDLE;
      default:          state_nxt = vmt_pkg::ST_IDLE;
    endcase
  end

  // A start flag clears counter and maximum before this element is counted.
  always_comb begin
    cnt_base  = ops_r.start ? '0 : cnt_r;
    best_base = ops_r.start ? '0 : best_r;
    elem_base = ops_r.start ? '0 : best_elem_r;
    comp_base = ops_r.start ? '0 : best_comp_r;
    cnt_new   = (cnt_base < vmt_pkg::MAX_ELEMENTS) ? cnt_base + 1'b1 : cnt_base;
    is_new    = (root_val > best_base);

    res_nxt.vm_stress      = root_val;
    res_nxt.element_number = cnt_new;
    res_nxt.new_max        = is_new;
    res_nxt.max_von_mises  = is_new ? root_val   : best_base;
    res_nxt.max_element    = is_new ? cnt_new    : elem_base;
    res_nxt.max_comp       = is_new ? ops_r.comp : comp_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vmt_pkg::ST_IDLE;
      phase_r     <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      best_r      <= '0;
      best_elem_r <= '0;
      best_comp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        phase_r    <= '0;
        prod_vld_r <= 1'b0;
      end else if (state_r == vmt_pkg::ST_MUL) begin
        phase_r    <= phase_r + 1'b1;
        prod_vld_r <= (phase_r < vmt_pkg::PH_MUL_END);
      end
      if (load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= res_nxt.element_number;
        best_r      <= res_nxt.max_von_mises;
        best_elem_r <= res_nxt.max_element;
        best_comp_r <= res_nxt.max_comp;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ops_r <= q_item;
      acc_r <= '0;
    end else if (state_r == vmt_pkg::ST_MUL) begin
      if (phase_r < vmt_pkg::PH_MUL_END) begin
        prod_r       <= sq;
        prod_shear_r <= (phase_r >= vmt_pkg::PH_SHEAR);
      end
      if (prod_vld_r) begin
        acc_r <= acc_r + weighted;
      end
    end
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

[rtl/von_mises_max_tracker.sv]
// Top level of the von Mises stress maximum tracker.
// The back end takes one word at a time, paced by the shared 25x25 squaring
// multiplier of the sequencer and the bit-serial square root (25 steps plus handoff).
// A two-word input queue keeps accepting while the back end is busy.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and clears
// the element counter and the stored maximum with its element number and components.
module von_mises_max_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vmt_pkg::STRESS_W-1:0]  in_sigma_x,
  input  logic signed [vmt_pkg::STRESS_W-1:0]  in_sigma_y,
  input  logic signed [vmt_pkg::STRESS_W-1:0]  in_sigma_z,
  input  logic signed [vmt_pkg::STRESS_W-1:0]  in_tau_xy,
  input  logic signed [vmt_pkg::STRESS_W-1:0]  in_tau_yz,
  input  logic signed [vmt_pkg::STRESS_W-1:0]  in_tau_zx,
  input  logic                                 in_start_of_set,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [vmt_pkg::VM_W-1:0]      out_von_mises,
  output logic        [vmt_pkg::NUM_W-1:0]     out_element_number,
  output logic                                 out_new_max,
  output logic        [vmt_pkg::VM_W-1:0]      out_max_von_mises,
  output logic        [vmt_pkg::NUM_W-1:0]     out_max_element,
  output logic signed [vmt_pkg::STRESS_W-1:0]  out_max_sigma_x,
  output logic signed [vmt_pkg::STRESS_W-1:0]  out_max_sigma_y,
  output logic signed [vmt_pkg::STRESS_W-1:0]  out_max_sigma_z,
  output logic signed [vmt_pkg::STRESS_W-1:0]  out_max_tau_xy,
  output logic signed [vmt_pkg::STRESS_W-1:0]  out_max_tau_yz,
  output logic signed [vmt_pkg::STRESS_W-1:0]  out_max_tau_zx
);

  // Components travel in the order sigma x, y, z, then tau xy, yz, zx.
  logic [vmt_pkg::N_COMP-1:0][vmt_pkg::STRESS_W-1:0] in_comp;
  logic                        q_valid, q_ready;
  vmt_pkg::item_t              q_item;
  logic                        root_start, root_done;
  logic [vmt_pkg::RAD_W-1:0]   root_rad;
  logic [vmt_pkg::ROOT_W-1:0]  root_val;
  vmt_pkg::result_t            res;

  assign in_comp[0] = in_sigma_x;
  assign in_comp[1] = in_sigma_y;
  assign in_comp[2] = in_sigma_z;
  assign in_comp[3] = in_tau_xy;
  assign in_comp[4] = in_tau_yz;
  assign in_comp[5] = in_tau_zx;

  // The front end forms the three normal differences as the word is taken,
  // so the back end only squares and accumulates.
  vmt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_comp  (in_comp),
    .in_start (in_start_of_set),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // The back end accumulates the normal squares plus six times the shear
  // squares; halving that sum is exact and gives the radicand.
  vmt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .root_start (root_start),
    .root_rad   (root_rad),
    .root_done  (root_done),
    .root_val   (root_val),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  vmt_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .rad   (root_rad),
    .done  (root_done),
    .root  (root_val)
  );

  assign out_von_mises      = res.vm_stress;
  assign out_element_number = res.element_number;
  assign out_new_max        = res.new_max;
  assign out_max_von_mises  = res.max_von_mises;
  assign out_max_element    = res.max_element;
  assign out_max_sigma_x    = res.max_comp[0];
  assign out_max_sigma_y    = res.max_comp[1];
  assign out_max_sigma_z    = res.max_comp[2];
  assign out_max_tau_xy     = res.max_comp[3];
  assign out_max_tau_yz     = res.max_comp[4];
  assign out_max_tau_zx     = res.max_comp[5];

  // A new maximum must be this word's own stress and element number.
  a_new_max_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_max |->
      out_max_von_mises == out_von_mises && out_max_element == out_element_number)
    else $error("new maximum does not match the current word");

  // A zero maximum can never have been claimed by an element.
  a_zero_max_no_element: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_max_von_mises == '0 |-> out_max_element == '0)
    else $error("element recorded for a zero maximum");

  // Strict comparison against zero means a new maximum is never zero, and
  // every word carries a nonzero element number.
  a_new_max_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_element_number != '0 && (!out_new_max || out_von_mises != '0))
    else $error("zero element number or zero-valued new maximum");

endmodule
